@@ src/kvs_pkg.sv @@
`default_nettype none
package kvs_pkg;

  localparam int DEF_MAX_KEYS = 64;
  localparam int TW = 32;   // time width
  localparam int VW = 32;   // value width
  localparam int SLOTW = 6;
  localparam int SEGW = 6;
  localparam int CNTW = 7;
  localparam int FW = 16;   // factor width

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NXT,
    RD_LAST,
    RD_SEG
  } rd_sel_t;

  typedef struct packed {
    logic    wr;
    logic    cap;
    rd_sel_t rd_sel;
    logic    nxt_inc;
    logic    found;
    logic    direct;
    logic    start_cap;
    logic    end_cap;
    logic    div_init;
    logic    div_step;
    logic    mul;
    logic    add;
    logic [1:0] comp;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic n_one;
    logic t_lt;
    logic nxt_last;
  } stat_t;

endpackage
`default_nettype wire

@@ src/keyframe_vector_sampler_core.sv @@
// A load item writes its key to the table and gives no result; the block stays ready.
// A sample compares keys one at a time through one registered read port, then reads
// the segment's start and end keys, runs 16 divider steps, blends x, y and z and loads
// the output register, waiting while the output is stalled; past the last key or for a
// single key it outputs that key directly. No new item is taken until the result is loaded.
// Reset (rst, synchronous) clears control and sets key_count to 1; tables are not cleared.
`default_nettype none
module keyframe_vector_sampler_core
  import kvs_pkg::*;
#(
  parameter int MAX_KEYS = DEF_MAX_KEYS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [CNTW-1:0] cfg_wdata,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic action,
  input  wire logic [SLOTW-1:0] key_slot,
  input  wire logic [TW-1:0] key_time,
  input  wire logic signed [VW-1:0] key_x,
  input  wire logic signed [VW-1:0] key_y,
  input  wire logic signed [VW-1:0] key_z,
  input  wire logic [TW-1:0] sample_time,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [VW-1:0] result_x,
  output logic signed [VW-1:0] result_y,
  output logic signed [VW-1:0] result_z,
  output logic [SEGW-1:0] segment
);

  cmd_t cmd;
  stat_t stat;

  kvs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .action(action),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  kvs_dpath #(.MAX_KEYS(MAX_KEYS)) u_dpath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .key_slot(key_slot), .key_time(key_time), .key_x(key_x), .key_y(key_y),
    .key_z(key_z), .sample_time(sample_time), .cmd(cmd), .stat(stat),
    .result_x(result_x), .result_y(result_y), .result_z(result_z),
    .segment(segment)
  );

  // Loads finish at once
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_LOAD |=> !in_stall)
    else $error("load item held the input");

  // Samples occupy the block
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_SAMPLE |=> in_stall)
    else $error("sample item did not start work");

  // A new result only follows work in progress
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample");

endmodule
`default_nettype wire

@@ src/kvs_ctrl.sv @@
`default_nettype none
module kvs_ctrl
  import kvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic action,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire stat_t stat,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_CMP, S_RDL, S_DIRECT, S_RDS, S_RDE, S_DIVI, S_DIV,
    S_MUL, S_ADD, S_OUT
  } state_t;

  state_t state;
  logic [3:0] div_cnt;
  logic [1:0] comp;
  logic accept, out_free;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Decode commands from state
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_ZERO;
    cmd.comp = comp;
    case (state)
      S_IDLE: begin
        cmd.wr = accept && (action == ACT_LOAD);
        cmd.cap = accept && (action == ACT_SAMPLE);
      end
      S_START: cmd.rd_sel = stat.n_one ? RD_ZERO : RD_NXT;
      S_CMP: begin
        cmd.found = stat.t_lt;
        cmd.nxt_inc = !stat.t_lt && !stat.nxt_last;
      end
      S_RDL: cmd.rd_sel = RD_LAST;
      S_DIRECT: cmd.direct = 1'b1;
      S_RDS: cmd.rd_sel = RD_SEG;
      S_RDE: begin
        cmd.start_cap = 1'b1;
        cmd.rd_sel = RD_NXT;
      end
      S_DIVI: begin
        cmd.end_cap = 1'b1;
        cmd.div_init = 1'b1;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_MUL: cmd.mul = 1'b1;
      S_ADD: cmd.add = 1'b1;
      S_OUT: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_cnt <= '0;
      comp <= '0;
    end else begin
      // Raise valid on an output load, drop it once the item is taken
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.cap) state <= S_START;
        S_START: state <= stat.n_one ? S_DIRECT : S_CMP;
        S_CMP: begin
          if (stat.t_lt) state <= S_RDS;
          else if (stat.nxt_last) state <= S_RDL;
          else state <= S_START;
        end
        S_RDL: state <= S_DIRECT;
        S_DIRECT: state <= S_OUT;
        S_RDS: state <= S_RDE;
        S_RDE: state <= S_DIVI;
        S_DIVI: begin
          div_cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(FW - 1)) begin
            comp <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: begin
          if (comp == 2'd2) state <= S_OUT;
          else begin
            comp <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/kvs_dpath.sv @@
`default_nettype none
module kvs_dpath
  import kvs_pkg::*;
#(
  parameter int MAX_KEYS = DEF_MAX_KEYS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [CNTW-1:0] cfg_wdata,
  input  wire logic [SLOTW-1:0] key_slot,
  input  wire logic [TW-1:0] key_time,
  input  wire logic signed [VW-1:0] key_x,
  input  wire logic signed [VW-1:0] key_y,
  input  wire logic signed [VW-1:0] key_z,
  input  wire logic [TW-1:0] sample_time,
  input  wire cmd_t cmd,
  output stat_t stat,
  output logic signed [VW-1:0] result_x,
  output logic signed [VW-1:0] result_y,
  output logic signed [VW-1:0] result_z,
  output logic [SEGW-1:0] segment
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int EW = ((NW > CNTW) ? NW : CNTW) + 1;
  localparam int SW = ((AW > SLOTW) ? AW : SLOTW) + 1;
  localparam int XW = (AW > SEGW) ? AW : SEGW;
  localparam int DW = VW + 1;
  localparam int PW = DW + FW + 1;

  logic [TW-1:0] time_mem [MAX_KEYS];
  logic [VW-1:0] x_mem [MAX_KEYS];
  logic [VW-1:0] y_mem [MAX_KEYS];
  logic [VW-1:0] z_mem [MAX_KEYS];

  logic [CNTW-1:0] key_count;
  logic [TW-1:0] t, t0, t1, rd_t, dvs;
  logic [VW-1:0] rd_x, rd_y, rd_z;
  logic [AW-1:0] last, nxt, seg, rd_addr, last_next;
  logic signed [VW-1:0] s_val [3];
  logic signed [VW-1:0] e_val [3];
  logic signed [VW-1:0] res [3];
  logic [SEGW-1:0] res_seg;
  logic [TW-1:0] rem;
  logic [FW-1:0] quo;
  logic fzero;
  logic signed [PW-1:0] prod;
  logic [SW-1:0] slot_ext;
  logic [EW-1:0] kc_ext;
  logic [XW-1:0] seg_ext, lastm1_ext;
  logic [TW:0] rem_sh;
  logic signed [DW-1:0] diff;
  logic signed [PW-FW-1:0] prod_sh;

  // Clamp key count to 1..MAX_KEYS, kept as index of the last key
  always_comb begin
    kc_ext = EW'(key_count);
    if (kc_ext == '0) last_next = '0;
    else if (kc_ext > EW'(MAX_KEYS)) last_next = AW'(MAX_KEYS - 1);
    else last_next = AW'(kc_ext - EW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) key_count <= CNTW'(1);
    else if (cfg_we) key_count <= cfg_wdata;
  end

  // Key table write port
  assign slot_ext = SW'(key_slot);
  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ext < SW'(MAX_KEYS)) begin
      time_mem[slot_ext[AW-1:0]] <= key_time;
      x_mem[slot_ext[AW-1:0]] <= key_x;
      y_mem[slot_ext[AW-1:0]] <= key_y;
      z_mem[slot_ext[AW-1:0]] <= key_z;
    end
  end

  // Key table read port, registered
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_NXT:  rd_addr = nxt;
      RD_LAST: rd_addr = last;
      RD_SEG:  rd_addr = seg;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_t <= time_mem[rd_addr];
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
    rd_z <= z_mem[rd_addr];
  end

  assign stat.n_one = (last == '0);
  assign stat.t_lt = (t < rd_t);
  assign stat.nxt_last = (nxt == last);

  assign seg_ext = XW'(seg);
  assign lastm1_ext = XW'(last - AW'(1));
  assign rem_sh = {rem, 1'b0};
  assign diff = DW'(e_val[cmd.comp]) - DW'(s_val[cmd.comp]);
  assign prod_sh = (PW-FW)'(prod >>> FW);

  // Search, divide and blend registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      t <= sample_time;
      last <= last_next;
      nxt <= AW'(1);
    end
    if (cmd.nxt_inc) nxt <= nxt + AW'(1);
    if (cmd.found) begin
      seg <= nxt - AW'(1);
      t1 <= rd_t;
    end
    if (cmd.direct) begin
      res[0] <= rd_x;
      res[1] <= rd_y;
      res[2] <= rd_z;
      res_seg <= (last == '0) ? '0 : lastm1_ext[SEGW-1:0];
    end
    if (cmd.start_cap) begin
      t0 <= rd_t;
      s_val[0] <= rd_x;
      s_val[1] <= rd_y;
      s_val[2] <= rd_z;
    end
    if (cmd.end_cap) begin
      e_val[0] <= rd_x;
      e_val[1] <= rd_y;
      e_val[2] <= rd_z;
    end
    if (cmd.div_init) begin
      fzero <= (t1 <= t0) || (t <= t0);
      rem <= t - t0;
      dvs <= t1 - t0;
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= TW'(rem_sh - {1'b0, dvs});
        quo <= {quo[FW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[TW-1:0];
        quo <= {quo[FW-2:0], 1'b0};
      end
    end
    if (cmd.mul) prod <= PW'(diff) * PW'($signed({1'b0, (fzero ? FW'(0) : quo)}));
    if (cmd.add) begin
      res[cmd.comp] <= VW'(PW'(s_val[cmd.comp]) + PW'(prod_sh));
      res_seg <= seg_ext[SEGW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_x <= res[0];
      result_y <= res[1];
      result_z <= res[2];
      segment <= res_seg;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb
  import kvs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS = DEF_MAX_KEYS;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic [SEGW-1:0] seg;
  } vec_t;

  typedef struct {
    bit is_cfg;
    logic act;
    logic [SLOTW-1:0] slot;
    logic [TW-1:0] t;
    logic [VW-1:0] x, y, z;
    logic [TW-1:0] st;
    bit has_exp;
    vec_t exp_v;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CNTW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_LOAD;
  logic [SLOTW-1:0] key_slot = '0;
  logic [TW-1:0] key_time = '0;
  logic signed [VW-1:0] key_x = '0, key_y = '0, key_z = '0;
  logic [TW-1:0] sample_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] result_x, result_y, result_z;
  logic [SEGW-1:0] segment;

  // track copy and pending interpolation results
  logic [TW-1:0] times [NKEYS];
  logic [VW-1:0] xs [NKEYS], ys [NKEYS], zs [NKEYS];
  logic [CNTW-1:0] track_len = 1;
  vec_t pending_vecs [$];
  row_t dir_rows [$];

  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  keyframe_vector_sampler_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .key_slot(key_slot), .key_time(key_time), .key_x(key_x), .key_y(key_y),
    .key_z(key_z), .sample_time(sample_time), .out_valid(out_valid),
    .out_stall(out_stall), .result_x(result_x), .result_y(result_y),
    .result_z(result_z), .segment(segment)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // end the run at the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // append one directed row
  function automatic void add_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [VW-1:0] blend(input logic [VW-1:0] a,
                                          input logic [VW-1:0] b,
                                          input logic [16:0] f);
    longint s, e, d;
    s = longint'($signed(a));
    e = longint'($signed(b));
    d = (e - s) * longint'(f);
    return VW'(s + (d >>> 16));
  endfunction

  function automatic vec_t interpolate(input logic [TW-1:0] t);
    vec_t r;
    int n, sg;
    bit hit;
    logic [63:0] q;
    logic [16:0] f;
    n = track_len;
    if (n == 0) n = 1;
    if (n > NKEYS) n = NKEYS;
    if (n == 1) begin
      r = '{xs[0], ys[0], zs[0], '0};
      return r;
    end
    hit = 1'b0;
    sg = 0;
    for (int k = 1; k < n; k++) begin
      if (!hit && t < times[k]) begin
        sg = k - 1;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      r = '{xs[n-1], ys[n-1], zs[n-1], SEGW'(n - 2)};
      return r;
    end
    if (times[sg+1] <= times[sg] || t <= times[sg]) begin
      f = '0;
    end else begin
      q = {32'(t - times[sg]), 16'h0} / 64'(times[sg+1] - times[sg]);
      f = (q > 64'h10000) ? 17'h10000 : q[16:0];
    end
    r.x = blend(xs[sg], xs[sg+1], f);
    r.y = blend(ys[sg], ys[sg+1], f);
    r.z = blend(zs[sg], zs[sg+1], f);
    r.seg = SEGW'(sg);
    return r;
  endfunction

  // offer one item, hold it until taken, then update the track copy
  task automatic send(input logic act, input logic [SLOTW-1:0] slot,
                      input logic [TW-1:0] t, input logic [VW-1:0] x,
                      input logic [VW-1:0] y, input logic [VW-1:0] z,
                      input logic [TW-1:0] st);
    in_valid <= 1'b1;
    action <= act;
    key_slot <= slot;
    key_time <= t;
    key_x <= x;
    key_y <= y;
    key_z <= z;
    sample_time <= st;
    do @(posedge clk); while (in_stall);
    if (act == ACT_LOAD) begin
      times[slot] = t;
      xs[slot] = x;
      ys[slot] = y;
      zs[slot] = z;
    end else begin
      pending_vecs.insert(pending_vecs.size(), interpolate(st));
    end
    // random gap after the item
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // wait out all pending results, then let a trailing load settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vecs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_len(input logic [CNTW-1:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    track_len = n;
  endtask

  // rebuild the used part of the track in non-decreasing time order
  task automatic load_track(input int n);
    logic [TW-1:0] t;
    t = $urandom_range(0, 32'h0100_0000);
    for (int k = 0; k < n; k++) begin
      send(ACT_LOAD, SLOTW'(k), t, $urandom, $urandom, $urandom, '0);
      if ($urandom_range(9) != 0) t = t + $urandom_range(1, 32'h0200_0000);
    end
  endtask

  function automatic logic [TW-1:0] pick_time(input int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(4))
      0: return $urandom;
      1: return times[k];
      default: return times[k] + $urandom_range(0, 32'h0100_0000) - 32'h0008_0000;
    endcase
  endfunction

  // compare each result with the oldest expectation; drive stall
  initial begin : receiver
    int hold_left;
    vec_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_vecs.size() == 0) begin
          report_mismatch("result with nothing pending", result_x, '0);
        end else begin
          want = pending_vecs.pop_front();
          if (result_x !== want.x) report_mismatch("result_x", result_x, want.x);
          if (result_y !== want.y) report_mismatch("result_y", result_y, want.y);
          if (result_z !== want.z) report_mismatch("result_z", result_z, want.z);
          if (segment !== want.seg) report_mismatch("segment", 32'(segment), 32'(want.seg));
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

  initial begin : sender
    row_t rw;
    vec_t got_first;
    int n;
    int lens [6];

    // directed rows: single key, extremes, clamps, equal and descending times
    add_row('{0, ACT_LOAD, 6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0, 0, 0, '0});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0, 1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}});
    add_row('{0, ACT_LOAD, 6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0001_0000, 0, 0, '0});
    add_row('{0, ACT_LOAD, 6'd2, 32'h0003_0000, 32'd1, 32'd2, 32'd3, 0, 0, '0});
    add_row('{0, ACT_LOAD, 6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 0, 0, '0});
    add_row('{1, ACT_LOAD, 6'd4, 0, 0, 0, 0, 0, 0, '0});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0, 1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0002_0000, 0, '0});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0003_0000, 1,
              '{32'd1, 32'd2, 32'd3, 6'd2}});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1,
              '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd2}});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0001_0000, 1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}});
    add_row('{0, ACT_LOAD, 6'd1, 32'h0000_8000, 32'd5, 32'd6, 32'd7, 0, 0, '0});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0000_4000, 1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}});
    add_row('{0, ACT_SAMPLE, 6'd0, 0, 0, 0, 0, 32'h0002_0000, 0, '0});

    for (int k = 0; k < NKEYS; k++) begin
      times[k] = '0; xs[k] = '0; ys[k] = '0; zs[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table; typed-in results must match the prediction
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      if (rw.is_cfg) begin
        write_len(CNTW'(rw.slot));
      end else begin
        if (rw.has_exp) begin
          got_first = interpolate(rw.st);
          if (got_first !== rw.exp_v) begin
            report_mismatch($sformatf("row %0d table x", i), got_first.x, rw.exp_v.x);
          end
        end
        send(rw.act, rw.slot, rw.t, rw.x, rw.y, rw.z, rw.st);
      end
    end

    // fill the whole table, then sample the full-length track
    write_len(7'd64);
    calm = 1'b1;
    load_track(NKEYS);
    send(ACT_LOAD, 6'd63, 32'hFFFF_FFFF, $urandom, $urandom, $urandom, '0);
    for (int k = 0; k < 20; k++) send(ACT_SAMPLE, '0, '0, '0, '0, '0, pick_time(NKEYS));
    calm = 1'b0;

    // random phases over several track lengths
    lens = '{1, 2, 64, 3, 8, 17};
    foreach (lens[p]) begin
      n = (p == 5) ? $urandom_range(2, 63) : lens[p];
      write_len(CNTW'(n));
      if (n > 1) load_track(n);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < 60; k++) begin
        if (k == 30) drain();
        case ($urandom_range(9))
          0: send(ACT_LOAD, SLOTW'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom);
          1: send(ACT_LOAD, SLOTW'($urandom_range(0, n - 1)), pick_time(n), $urandom,
                  $urandom, $urandom, $urandom);
          default: send(ACT_SAMPLE, SLOTW'($urandom), $urandom, $urandom, $urandom,
                        $urandom, pick_time(n));
        endcase
      end
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/kvs_pkg.sv
src/kvs_ctrl.sv
src/kvs_dpath.sv
src/keyframe_vector_sampler_core.sv
tb/tb.sv
